### rtl/core/wcg_pkg.sv
package wcg_pkg;

	// Length clamp and default output precision
	localparam int MAX_LENGTH     = 4096;
	localparam int COEF_FRAC_BITS = 16;

	// Pipeline depths of the arithmetic units
	localparam int DIV_STEPS = 32;
	localparam int COS_LAT   = 22;
	localparam int EXP_LAT   = 40;

	// Q30 constants
	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [29:0] C054 = 30'((64'd1073741824 * 64'd54 + 64'd50) / 64'd100);
	localparam logic [29:0] C046 = 30'((64'd1073741824 * 64'd46 + 64'd50) / 64'd100);
	localparam logic [29:0] C062 = 30'((64'd1073741824 * 64'd62 + 64'd50) / 64'd100);
	localparam logic [29:0] C048 = 30'((64'd1073741824 * 64'd48 + 64'd50) / 64'd100);
	localparam logic [29:0] C038 = 30'((64'd1073741824 * 64'd38 + 64'd50) / 64'd100);
	localparam logic [29:0] C042 = 30'((64'd1073741824 * 64'd42 + 64'd50) / 64'd100);
	localparam logic [29:0] C008 = 30'((64'd1073741824 * 64'd8 + 64'd50) / 64'd100);

	// Configuration register indexes
	localparam logic [1:0] REG_KIND   = 2'd0;
	localparam logic [1:0] REG_LENGTH = 2'd1;
	localparam logic [1:0] REG_ALPHA  = 2'd2;

	// Register reset values
	localparam logic [12:0] LENGTH_RESET = 13'd1024;
	localparam logic [10:0] ALPHA_RESET  = 11'd640;

	typedef enum logic [2:0] {
		KIND_RECT,
		KIND_HAMMING,
		KIND_HANN,
		KIND_GAUSS,
		KIND_BART_HANN,
		KIND_BLACKMAN,
		KIND_BARTLETT
	} kind_t;

endpackage

### rtl/core/wcg_div.sv
// Restoring divider, one quotient bit per stage. The user must keep the divisor static while items flow; not enforced.
module wcg_div (
	input  logic        clk,
	input  logic        en,
	input  logic [43:0] dividend,
	input  logic [12:0] divisor,
	output logic [31:0] quotient
);

	localparam int STEPS = wcg_pkg::DIV_STEPS;

	logic [12:0] rem_s  [1:STEPS];
	logic [31:0] bits_s [1:STEPS];

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		logic [12:0] rem_prev;
		logic [31:0] bits_prev;
		logic [13:0] trial;
		logic        ge;

		if (g == 0) begin : g_first
			assign rem_prev  = {1'b0, dividend[43:32]};
			assign bits_prev = dividend[31:0];
		end else begin : g_next
			assign rem_prev  = rem_s[g];
			assign bits_prev = bits_s[g];
		end

		// shift in next dividend bit, subtract when it fits
		assign trial = {rem_prev, bits_prev[31]};
		assign ge    = trial >= {1'b0, divisor};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= ge ? 13'(trial - {1'b0, divisor}) : trial[12:0];
				bits_s[g+1] <= {bits_prev[30:0], ge};
			end
		end
	end

	assign quotient = bits_s[STEPS];

endmodule

### rtl/core/wcg_horner.sv
// One Horner step t' = 1 - ((a * t) >> 30) / DIVISOR, three stages.
// Division by the constant is a reciprocal multiply plus one correction.
module wcg_horner #(
	parameter int DIVISOR = 2
) (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a_in,
	input  logic [30:0] t_in,
	output logic [31:0] a_out,
	output logic [30:0] t_out
);

	localparam int          FLOOR_LOG2 = $clog2(DIVISOR + 1) - 1;
	localparam logic [32:0] RECIP      = 33'((64'd1 << (32 + FLOOR_LOG2)) / DIVISOR);

	logic [31:0] a_s1, a_s2, a_s3;
	logic [31:0] p_s1, p_s2;
	logic [31:0] q0_s2;
	logic [30:0] t_s3;

	logic [64:0] scaled;
	logic [39:0] back;
	logic [39:0] rem;
	logic [31:0] quo;

	assign scaled = {33'b0, p_s1} * {32'b0, RECIP};
	assign back   = 40'(q0_s2) * 40'(DIVISOR);
	assign rem    = 40'(p_s2) - back;
	assign quo    = (rem >= 40'(DIVISOR)) ? q0_s2 + 32'd1 : q0_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			// product
			p_s1  <= 32'((64'(a_in) * 64'(t_in)) >> 30);
			a_s1  <= a_in;
			// quotient estimate, low by at most one
			q0_s2 <= 32'(scaled >> (32 + FLOOR_LOG2));
			p_s2  <= p_s1;
			a_s2  <= a_s1;
			// correction and subtract from one
			t_s3  <= 31'(33'(wcg_pkg::ONE_Q30) - 33'(quo));
			a_s3  <= a_s2;
		end
	end

	assign a_out = a_s3;
	assign t_out = t_s3;

endmodule

### rtl/core/wcg_cos.sv
// cos(2*pi*phase/2^32) in signed Q30: quarter-wave fold, Taylor series by Horner steps.
module wcg_cos (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        phase,
	output logic signed [31:0] cosine
);

	localparam int TERMS = 6;

	logic [1:0]  quad_s1, quad_s2, quad_s21;
	logic [30:0] x_s1;
	logic [31:0] x2_s2;
	logic [31:0] p_s21;
	logic signed [31:0] cos_s22;
	logic [1:0]  quad_dly [3*TERMS];

	logic [30:0] r_fold;
	logic [31:0] a_h [TERMS+1];
	logic [30:0] t_h [TERMS+1];
	logic signed [32:0] c_pos;

	// fold odd quadrants onto the first
	assign r_fold = phase[30] ? 31'(wcg_pkg::ONE_Q30) - {1'b0, phase[29:0]}
	                          : {1'b0, phase[29:0]};

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1 <= phase[31:30];
			x_s1    <= 31'((62'(r_fold) * 62'(wcg_pkg::HALF_PI_Q30)) >> 30);
			quad_s2 <= quad_s1;
			x2_s2   <= 32'((62'(x_s1) * 62'(x_s1)) >> 30);
		end
	end

	// Horner chain, k = 7 down to 2
	assign a_h[0] = x2_s2;
	assign t_h[0] = wcg_pkg::ONE_Q30;

	for (genvar g = 0; g < TERMS; g++) begin : g_term
		localparam int K = 7 - g;
		wcg_horner #(
			.DIVISOR((2 * K - 1) * (2 * K))
		) u_step (
			.clk  (clk),
			.en   (en),
			.a_in (a_h[g]),
			.t_in (t_h[g]),
			.a_out(a_h[g+1]),
			.t_out(t_h[g+1])
		);
	end

	// quadrant rides alongside the Horner chain
	always_ff @(posedge clk) begin
		if (en) begin
			quad_dly[0] <= quad_s2;
			for (int j = 1; j < 3 * TERMS; j++) begin
				quad_dly[j] <= quad_dly[j-1];
			end
		end
	end

	// last term and sign
	assign c_pos = $signed({2'b0, wcg_pkg::ONE_Q30}) - $signed({2'b0, p_s21[31:1]});

	always_ff @(posedge clk) begin
		if (en) begin
			p_s21    <= 32'((64'(a_h[TERMS]) * 64'(t_h[TERMS])) >> 30);
			quad_s21 <= quad_dly[3*TERMS-1];
			cos_s22  <= (quad_s21[1] ^ quad_s21[0]) ? 32'(-c_pos) : 32'(c_pos);
		end
	end

	assign cosine = cos_s22;

endmodule

### rtl/core/wcg_exp.sv
// exp(-z*z/2^11) in Q30: argument scaled by 1/64, series by Horner steps, six squarings.
module wcg_exp (
	input  logic        clk,
	input  logic        en,
	input  logic [22:0] z,
	output logic [30:0] value
);

	localparam int TERMS   = 11;
	localparam int SQUARES = 6;

	logic [28:0] w_s1;
	logic [31:0] a_h [TERMS];
	logic [30:0] t_h [TERMS+1];
	logic [30:0] sq_s [SQUARES];

	// w = ((z*z) >> 11) >> 6
	always_ff @(posedge clk) begin
		if (en) begin
			w_s1 <= 29'((46'(z) * 46'(z)) >> 17);
		end
	end

	assign a_h[0] = {3'b0, w_s1};
	assign t_h[0] = wcg_pkg::ONE_Q30;

	for (genvar g = 0; g < TERMS; g++) begin : g_term
		if (g < TERMS - 1) begin : g_mid
			wcg_horner #(
				.DIVISOR(TERMS - g)
			) u_step (
				.clk  (clk),
				.en   (en),
				.a_in (a_h[g]),
				.t_in (t_h[g]),
				.a_out(a_h[g+1]),
				.t_out(t_h[g+1])
			);
		end else begin : g_last
			wcg_horner #(
				.DIVISOR(TERMS - g)
			) u_step (
				.clk  (clk),
				.en   (en),
				.a_in (a_h[g]),
				.t_in (t_h[g]),
				.a_out(),
				.t_out(t_h[g+1])
			);
		end
	end

	// square back up
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s[0] <= 31'((62'(t_h[TERMS]) * 62'(t_h[TERMS])) >> 30);
			for (int j = 1; j < SQUARES; j++) begin
				sq_s[j] <= 31'((62'(sq_s[j-1]) * 62'(sq_s[j-1])) >> 30);
			end
		end
	end

	assign value = sq_s[SQUARES-1];

endmodule

### rtl/core/window_coefficient_generator_core.sv
// Pipeline: 2 front stages, 32-stage divider, 40-stage exponential unit with the cosine units
// behind a phase delay line, 2 combine stages, output register.
// Throughput: one item per cycle; the pipeline holds only while the two-entry output
// buffer is full.
// Reset: arst_n clears valid bits and loads kind rectangular, length 1024, alpha 2.5.
module window_coefficient_generator_core #(
	parameter int COEF_FRAC_BITS = wcg_pkg::COEF_FRAC_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // [11:0] sample_index
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [((COEF_FRAC_BITS+8)/8)*8-1:0] m_tdata, // [COEF_FRAC_BITS:0] coefficient
	output logic              m_tuser,   // [0] index_out_of_range
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [12:0]       cfg_data
);

	localparam int DATA_W = ((COEF_FRAC_BITS + 8) / 8) * 8;
	localparam int COEF_W = COEF_FRAC_BITS + 1;
	localparam int SHIFT  = 30 - COEF_FRAC_BITS;
	localparam int DEPTH  = 2 + wcg_pkg::DIV_STEPS + wcg_pkg::EXP_LAT + 2;
	localparam int PH_DLY = wcg_pkg::EXP_LAT;
	localparam int COS_TAP = wcg_pkg::EXP_LAT - wcg_pkg::COS_LAT - 1;
	localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

	localparam logic signed [33:0] ONE_S  = 34'(wcg_pkg::ONE_Q30);
	localparam logic signed [33:0] TWO_S  = 34'(wcg_pkg::ONE_Q30) <<< 1;
	localparam logic signed [33:0] C054_S = 34'(wcg_pkg::C054);
	localparam logic signed [33:0] C062_S = 34'(wcg_pkg::C062);
	localparam logic signed [33:0] C042_S = 34'(wcg_pkg::C042);

	typedef struct packed {
		logic valid;
		logic oor;
		logic low_half;
	} side_t;

	// configuration
	wcg_pkg::kind_t kind_q;
	logic [12:0]    len_q;
	logic [10:0]    alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= wcg_pkg::KIND_RECT;
			len_q   <= wcg_pkg::LENGTH_RESET;
			alpha_q <= wcg_pkg::ALPHA_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wcg_pkg::REG_KIND:   kind_q  <= wcg_pkg::kind_t'(cfg_data[2:0]);
				wcg_pkg::REG_LENGTH: len_q   <= cfg_data;
				wcg_pkg::REG_ALPHA:  alpha_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// flow control
	logic en;
	logic out_valid_q, spare_valid_q;
	logic push, pop;

	assign en       = !spare_valid_q;
	assign s_tready = en;

	// stage 1: length clamp, range check, |2i - N|
	logic [11:0] idx;
	logic [12:0] n_eff;
	logic [12:0] two_i;
	logic [11:0] idx_s1;
	logic [12:0] span_s1;
	side_t       side_s [DEPTH];

	assign idx   = s_tdata[11:0];
	assign n_eff = (32'(len_q) > wcg_pkg::MAX_LENGTH) ? 13'(wcg_pkg::MAX_LENGTH) : len_q;
	assign two_i = {idx, 1'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1  <= idx;
			span_s1 <= (two_i >= n_eff) ? two_i - n_eff : n_eff - two_i;
		end
	end

	// valid and per-item flags travel the whole pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DEPTH; j++) begin
				side_s[j] <= '0;
			end
		end else if (en) begin
			side_s[0].valid    <= s_tvalid;
			side_s[0].oor      <= {1'b0, idx} >= n_eff;
			side_s[0].low_half <= {1'b0, idx} < {1'b0, n_eff[12:1]};
			for (int j = 1; j < DEPTH; j++) begin
				side_s[j] <= side_s[j-1];
			end
		end
	end

	// stage 2: dividend for phase or Gaussian ratio
	logic [43:0] dividend_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			if (kind_q == wcg_pkg::KIND_GAUSS) begin
				dividend_s2 <= {8'b0, 24'(alpha_q) * 24'(span_s1), 12'b0};
			end else begin
				dividend_s2 <= {idx_s1, 32'b0};
			end
		end
	end

	logic [31:0] quo;

	wcg_div u_div (
		.clk     (clk),
		.en      (en),
		.dividend(dividend_s2),
		.divisor (n_eff),
		.quotient(quo)
	);

	// phase delay line, tapped for the cosine units
	logic [31:0] ph_dly [PH_DLY];

	always_ff @(posedge clk) begin
		if (en) begin
			ph_dly[0] <= quo;
			for (int j = 1; j < PH_DLY; j++) begin
				ph_dly[j] <= ph_dly[j-1];
			end
		end
	end

	logic [31:0] arg_a, arg_b, ph_tap;
	logic signed [31:0] cos_a, cos_b;
	logic [30:0] exp_v;

	assign ph_tap = ph_dly[COS_TAP];
	assign arg_a  = (kind_q == wcg_pkg::KIND_BART_HANN) ? {~ph_tap[31], ph_tap[30:0]} : ph_tap;
	assign arg_b  = {ph_tap[30:0], 1'b0};

	wcg_cos u_cos_a (
		.clk   (clk),
		.en    (en),
		.phase (arg_a),
		.cosine(cos_a)
	);

	wcg_cos u_cos_b (
		.clk   (clk),
		.en    (en),
		.phase (arg_b),
		.cosine(cos_b)
	);

	wcg_exp u_exp (
		.clk  (clk),
		.en   (en),
		.z    (quo[22:0]),
		.value(exp_v)
	);

	// stage 3: constant products
	logic [31:0] ph_end;
	logic [31:0] mag_a, mag_b, tri_m;
	logic [29:0] k_a;
	logic [31:0] prod_a, prod_b;

	logic signed [32:0] mul_a_s3, mul_b_s3;
	logic [29:0]        mul_m_s3;
	logic signed [31:0] cos_a_s3;
	logic [30:0]        exp_s3;
	logic [31:0]        ph_s3;

	assign ph_end = ph_dly[PH_DLY-1];
	assign mag_a  = cos_a[31] ? 32'(-cos_a) : 32'(cos_a);
	assign mag_b  = cos_b[31] ? 32'(-cos_b) : 32'(cos_b);
	assign tri_m  = ph_end[31] ? {1'b0, ph_end[30:0]} : 32'h8000_0000 - ph_end;
	assign k_a    = (kind_q == wcg_pkg::KIND_HAMMING) ? wcg_pkg::C046 : wcg_pkg::C038;
	assign prod_a = 32'((62'(k_a) * 62'(mag_a)) >> 30);
	assign prod_b = 32'((62'(wcg_pkg::C008) * 62'(mag_b)) >> 30);

	always_ff @(posedge clk) begin
		if (en) begin
			mul_a_s3 <= cos_a[31] ? -$signed({1'b0, prod_a}) : $signed({1'b0, prod_a});
			mul_b_s3 <= cos_b[31] ? -$signed({1'b0, prod_b}) : $signed({1'b0, prod_b});
			mul_m_s3 <= 30'((62'(wcg_pkg::C048) * 62'(tri_m)) >> 32);
			cos_a_s3 <= cos_a;
			exp_s3   <= exp_v;
			ph_s3    <= ph_end;
		end
	end

	// stage 4: window formula
	logic signed [33:0] ma, mb, mm, ca, ca_half, ex, bt, v_next;
	logic signed [33:0] v_s4;

	assign ma      = 34'(mul_a_s3);
	assign mb      = 34'(mul_b_s3);
	assign mm      = 34'(mul_m_s3);
	assign ca      = 34'(cos_a_s3);
	assign ex      = 34'(exp_s3);
	assign bt      = 34'(ph_s3[31:1]);
	// halve toward zero
	assign ca_half = (ca + $signed({33'b0, cos_a_s3[31]})) >>> 1;

	always_comb begin
		case (kind_q)
			wcg_pkg::KIND_HAMMING:   v_next = C054_S - ma;
			wcg_pkg::KIND_HANN:      v_next = (ONE_S - ca) >>> 1;
			wcg_pkg::KIND_GAUSS:     v_next = ex;
			wcg_pkg::KIND_BART_HANN: v_next = C062_S - mm + ma;
			wcg_pkg::KIND_BLACKMAN:  v_next = C042_S - ca_half + mb;
			wcg_pkg::KIND_BARTLETT:  v_next = side_s[DEPTH-2].low_half ? bt : TWO_S - bt;
			default:                 v_next = ONE_S;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s4 <= v_next;
		end
	end

	// clamp to [0, 1.0] and round to output precision
	logic [30:0]       v_clamp;
	logic [COEF_W-1:0] coef;
	logic [COEF_W-1:0] coef_next;
	side_t             side_end;

	assign side_end = side_s[DEPTH-1];
	assign v_clamp  = v_s4[33] ? 31'd0 : (v_s4 > ONE_S) ? wcg_pkg::ONE_Q30 : v_s4[30:0];

	if (SHIFT > 0) begin : g_round
		logic [31:0] rounded;
		assign rounded = (32'(v_clamp) + (32'd1 << (SHIFT - 1))) >> SHIFT;
		assign coef    = rounded[COEF_W-1:0];
	end else begin : g_exact
		assign coef = v_clamp[COEF_W-1:0];
	end

	assign coef_next = side_end.oor ? '0 : coef;

	// two-entry output buffer
	logic [COEF_W-1:0] out_coef_q, spare_coef_q;
	logic              out_oor_q, spare_oor_q;

	assign push = en && side_end.valid;
	assign pop  = out_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (spare_valid_q) begin
					spare_valid_q <= push;
				end else begin
					out_valid_q <= push;
				end
			end else if (push) begin
				if (out_valid_q) begin
					spare_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && spare_valid_q) begin
			out_coef_q <= spare_coef_q;
			out_oor_q  <= spare_oor_q;
		end else if (push && (pop || !out_valid_q)) begin
			out_coef_q <= coef_next;
			out_oor_q  <= side_end.oor;
		end
		if (push && ((pop && spare_valid_q) || (!pop && out_valid_q))) begin
			spare_coef_q <= coef_next;
			spare_oor_q  <= side_end.oor;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = DATA_W'(out_coef_q);
	assign m_tuser  = out_oor_q;

	// checks
	a_spare_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		spare_valid_q |-> out_valid_q)
		else $error("output buffer spare holds data with empty head");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (out_coef_q == '0))
		else $error("out-of-range result with nonzero coefficient");

	a_coef_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_coef_q <= COEF_ONE))
		else $error("coefficient above 1.0");

endmodule
